>>> rtl/fbmvn_pkg.sv
package fbmvn_pkg;

   localparam int OCTAVES      = 4;
   localparam int HEIGHT_LIMIT = 256;
   localparam int SEED_STEP    = 97;

   localparam logic [31:0] HASH_CX  = 32'h27d4eb2d;
   localparam logic [31:0] HASH_CZ  = 32'h85ebca6b;
   localparam logic [31:0] HASH_M1  = 32'h7feb352d;
   localparam logic [31:0] HASH_M2  = 32'h846ca68b;
   localparam logic [31:0] LAT_MASK = 32'h00ffffff;

   // Q1.23 unit and the normaliser 15 * 2^23
   localparam longint Q23_ONE  = 64'd8388608;
   localparam longint LAT_HALF = 64'd8388607;
   localparam longint NORM_DEN = 15 * Q23_ONE;

   // floor(u / 15) == (u * RECIP15) >> RECIP_SHIFT for u below 74898
   localparam int RECIP15     = 34953;
   localparam int RECIP_SHIFT = 19;

   typedef enum logic [7:0] {
      REG_SEED  = 8'd0,
      REG_SCALE = 8'd1,
      REG_BASE  = 8'd2,
      REG_AMP   = 8'd3
   } csr_index_type;

   typedef logic signed [24:0] lat_type;
   typedef logic signed [43:0] blend_prod_type;

   // First half of the lattice hash, up to the first multiply
   function automatic logic [31:0] hash_front(logic [31:0] seed, logic [31:0] a,
                                              logic [31:0] b);
      logic [31:0] h;
      h = seed ^ a;
      h = {h[16:0], h[31:17]};
      h = h ^ b;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // Map the final hash to [-1, 1] in Q1.23, rounded half away from zero
   function automatic lat_type lattice_value(logic [31:0] h);
      logic [31:0] x;
      logic [23:0] m;
      x = h ^ (h >> 16);
      m = x[23:0];
      if (m[23])
         return lat_type'({1'b0, m}) - lat_type'(LAT_HALF);
      else
         return lat_type'({1'b0, m}) - lat_type'(Q23_ONE);
   endfunction

   // a + round(p / 2^16), half away from zero
   function automatic lat_type blend_round(lat_type a, blend_prod_type p);
      blend_prod_type q;
      blend_prod_type r;
      q = p + (p[43] ? 44'sd32767 : 44'sd32768);
      r = q >>> 16;
      return a + lat_type'(r[24:0]);
   endfunction

   // (t*t*(3*2^16 - 2t) + 2^31) >> 32
   function automatic logic [16:0] smooth_round(logic [49:0] prod);
      logic [50:0] s;
      s = {1'b0, prod} + 51'h80000000;
      return s[48:32];
   endfunction

endpackage

>>> rtl/fbm_value_noise_height_sampler.sv
// Fractal value-noise height sampler: each (world_x, world_z) transaction returns one
// terrain height built from four octaves of 2D value noise. One transaction can be
// accepted every cycle unless the output stalls with the pipeline full. The 15-stage
// pipeline covers the position multiply, the smoothstep and lattice hash multiplies,
// two bilinear blend levels and the final scale, round and saturate. A stall holds
// each full stage with no empty stage after it, while stages behind an empty one keep
// moving, so req_ready drops only when the whole pipeline is full and the result is
// not taken. Configuration writes are always accepted; write them only while idle.
module fbm_value_noise_height_sampler (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [23:0]  req_world_x,
   input  logic signed [23:0]  req_world_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_height,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [31:0]         csr_data
);

   localparam int NST = 15;
   localparam int OCT = fbmvn_pkg::OCTAVES;

   logic [31:0] seed_ff;
   logic [15:0] scale_ff;
   logic [7:0]  base_ff;
   logic [7:0]  amp_ff;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] adv;

   // stage data
   logic signed [23:0] wx0_ff, wz0_ff;
   logic signed [39:0] px1_ff, pz1_ff;
   logic [15:0] tx2_ff [OCT];
   logic [15:0] tz2_ff [OCT];
   logic [31:0] ttx2_ff [OCT];
   logic [31:0] ttz2_ff [OCT];
   logic [31:0] ax2_ff [OCT][2];
   logic [31:0] bz2_ff [OCT][2];
   logic [49:0] spx3_ff [OCT];
   logic [49:0] spz3_ff [OCT];
   logic [31:0] h3_ff [OCT][4];
   logic [16:0] sx4_ff [OCT];
   logic [16:0] sz4_ff [OCT];
   logic [31:0] h4_ff [OCT][4];
   fbmvn_pkg::lat_type v5_ff [OCT][4];
   logic [16:0] sx5_ff [OCT];
   logic [16:0] sz5_ff [OCT];
   fbmvn_pkg::blend_prod_type bp6_ff [OCT][2];
   fbmvn_pkg::lat_type a6_ff [OCT][2];
   logic [16:0] sz6_ff [OCT];
   fbmvn_pkg::lat_type l7_ff [OCT][2];
   logic [16:0] sz7_ff [OCT];
   fbmvn_pkg::blend_prod_type bp8_ff [OCT];
   fbmvn_pkg::lat_type a8_ff [OCT];
   fbmvn_pkg::lat_type n9_ff [OCT];
   logic signed [27:0] sum10_ff;
   logic signed [37:0] num11_ff;
   logic [14:0] u12_ff;
   logic        neg12_ff;
   logic [11:0] q13_ff;
   logic        neg13_ff;
   logic [7:0]  height_ff;

   logic [31:0] cx2_in [OCT];
   logic [31:0] cz2_in [OCT];
   logic [15:0] tx2_in [OCT];
   logic [15:0] tz2_in [OCT];

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= 32'd0;
         scale_ff <= 16'd1311;
         base_ff  <= 8'd64;
         amp_ff   <= 8'd32;
      end else if (csr_valid) begin
         case (csr_index)
            fbmvn_pkg::REG_SEED:  seed_ff  <= csr_data;
            fbmvn_pkg::REG_SCALE: scale_ff <= csr_data[15:0];
            fbmvn_pkg::REG_BASE:  base_ff  <= csr_data[7:0];
            fbmvn_pkg::REG_AMP:   amp_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // a stage advances when it is empty or its successor advances
   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign req_ready  = adv[0];
   assign rsp_valid  = vld_ff[NST-1];
   assign rsp_height = height_ff;

   // stage 0: capture the transaction
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         wx0_ff <= req_world_x;
         wz0_ff <= req_world_z;
      end
   end

   // stage 1: scaled position, Q.16
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         px1_ff <= 40'(wx0_ff * $signed({1'b0, scale_ff}));
         pz1_ff <= 40'(wz0_ff * $signed({1'b0, scale_ff}));
      end
   end

   // stage 2: per-octave cell and fraction, t*t and the first hash products
   always_comb begin
      logic signed [47:0] ex;
      logic signed [47:0] ez;
      for (int o = 0; o < OCT; o++) begin
         ex = 48'(px1_ff) <<< o;
         ez = 48'(pz1_ff) <<< o;
         cx2_in[o] = ex[47:16];
         cz2_in[o] = ez[47:16];
         tx2_in[o] = ex[15:0];
         tz2_in[o] = ez[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int o = 0; o < OCT; o++) begin
            tx2_ff[o]    <= tx2_in[o];
            tz2_ff[o]    <= tz2_in[o];
            ttx2_ff[o]   <= 32'(tx2_in[o] * tx2_in[o]);
            ttz2_ff[o]   <= 32'(tz2_in[o] * tz2_in[o]);
            ax2_ff[o][0] <= 32'(cx2_in[o] * fbmvn_pkg::HASH_CX);
            ax2_ff[o][1] <= 32'((cx2_in[o] + 32'd1) * fbmvn_pkg::HASH_CX);
            bz2_ff[o][0] <= 32'(cz2_in[o] * fbmvn_pkg::HASH_CZ);
            bz2_ff[o][1] <= 32'((cz2_in[o] + 32'd1) * fbmvn_pkg::HASH_CZ);
         end
      end
   end

   // stage 3: smoothstep product, hash mix and first multiply
   always_ff @(posedge clock) begin
      logic [31:0] os;
      if (adv[3]) begin
         for (int o = 0; o < OCT; o++) begin
            os = seed_ff + 32'(fbmvn_pkg::SEED_STEP * o);
            spx3_ff[o] <= 50'(ttx2_ff[o] * (18'd196608 - {1'b0, tx2_ff[o], 1'b0}));
            spz3_ff[o] <= 50'(ttz2_ff[o] * (18'd196608 - {1'b0, tz2_ff[o], 1'b0}));
            for (int c = 0; c < 4; c++) begin
               h3_ff[o][c] <= 32'(fbmvn_pkg::hash_front(os, ax2_ff[o][c % 2],
                                                        bz2_ff[o][c / 2])
                                  * fbmvn_pkg::HASH_M1);
            end
         end
      end
   end

   // stage 4: smoothstep weight, second hash multiply
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int o = 0; o < OCT; o++) begin
            sx4_ff[o] <= fbmvn_pkg::smooth_round(spx3_ff[o]);
            sz4_ff[o] <= fbmvn_pkg::smooth_round(spz3_ff[o]);
            for (int c = 0; c < 4; c++) begin
               h4_ff[o][c] <= 32'((h3_ff[o][c] ^ (h3_ff[o][c] >> 15)) * fbmvn_pkg::HASH_M2);
            end
         end
      end
   end

   // stage 5: lattice values
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int o = 0; o < OCT; o++) begin
            sx5_ff[o] <= sx4_ff[o];
            sz5_ff[o] <= sz4_ff[o];
            for (int c = 0; c < 4; c++) begin
               v5_ff[o][c] <= fbmvn_pkg::lattice_value(h4_ff[o][c]);
            end
         end
      end
   end

   // stage 6: x blend products for both rows
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         for (int o = 0; o < OCT; o++) begin
            for (int r = 0; r < 2; r++) begin
               a6_ff[o][r]  <= v5_ff[o][2*r];
               bp6_ff[o][r] <= 44'((26'(v5_ff[o][2*r+1]) - 26'(v5_ff[o][2*r]))
                                   * $signed({1'b0, sx5_ff[o]}));
            end
            sz6_ff[o] <= sz5_ff[o];
         end
      end
   end

   // stage 7: x blend results
   always_ff @(posedge clock) begin
      if (adv[7]) begin
         for (int o = 0; o < OCT; o++) begin
            for (int r = 0; r < 2; r++) begin
               l7_ff[o][r] <= fbmvn_pkg::blend_round(a6_ff[o][r], bp6_ff[o][r]);
            end
            sz7_ff[o] <= sz6_ff[o];
         end
      end
   end

   // stage 8: z blend product
   always_ff @(posedge clock) begin
      if (adv[8]) begin
         for (int o = 0; o < OCT; o++) begin
            a8_ff[o]  <= l7_ff[o][0];
            bp8_ff[o] <= 44'((26'(l7_ff[o][1]) - 26'(l7_ff[o][0]))
                             * $signed({1'b0, sz7_ff[o]}));
         end
      end
   end

   // stage 9: octave noise
   always_ff @(posedge clock) begin
      if (adv[9]) begin
         for (int o = 0; o < OCT; o++) begin
            n9_ff[o] <= fbmvn_pkg::blend_round(a8_ff[o], bp8_ff[o]);
         end
      end
   end

   // stage 10: weighted octave sum, octave i weighted by 2^(OCT-1-i)
   always_ff @(posedge clock) begin
      logic signed [27:0] acc;
      if (adv[10]) begin
         acc = '0;
         for (int o = 0; o < OCT; o++) begin
            acc = acc + (28'(n9_ff[o]) <<< (OCT - 1 - o));
         end
         sum10_ff <= acc;
      end
   end

   // stage 11: base * 15 * 2^23 + amplitude * sum
   always_ff @(posedge clock) begin
      if (adv[11]) begin
         num11_ff <= 38'($signed({1'b0, base_ff}) * 38'(fbmvn_pkg::NORM_DEN))
                   + 38'($signed({1'b0, amp_ff}) * sum10_ff);
      end
   end

   // stage 12: magnitude plus half, drop the 2^24 part of the divisor
   always_ff @(posedge clock) begin
      logic [37:0] mag;
      logic [38:0] b;
      if (adv[12]) begin
         mag = num11_ff[37] ? 38'(-num11_ff) : 38'(num11_ff);
         b   = {mag, 1'b0} + 39'(fbmvn_pkg::NORM_DEN);
         u12_ff   <= b[38:24];
         neg12_ff <= num11_ff[37];
      end
   end

   // stage 13: divide by 15 through the reciprocal
   always_ff @(posedge clock) begin
      logic [31:0] p;
      if (adv[13]) begin
         p = 32'(u12_ff * 17'(fbmvn_pkg::RECIP15));
         q13_ff   <= 12'(p >> fbmvn_pkg::RECIP_SHIFT);
         neg13_ff <= neg12_ff;
      end
   end

   // stage 14: saturate
   always_ff @(posedge clock) begin
      logic [31:0] y;
      if (adv[14]) begin
         if (neg13_ff)
            y = 32'd0;
         else if (32'(q13_ff) > 32'(fbmvn_pkg::HEIGHT_LIMIT - 1))
            y = 32'(fbmvn_pkg::HEIGHT_LIMIT - 1);
         else
            y = 32'(q13_ff);
         height_ff <= y[7:0];
      end
   end

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && (&vld_ff)))
      else $error("input stalled while pipeline has room");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (adv[NST-1] && vld_ff[NST-2]) |=> rsp_valid)
      else $error("result lost in last stage");

   a_negative_clamps: assert property (@(posedge clock) disable iff (reset)
      (adv[14] && vld_ff[13] && neg13_ff) |=> (rsp_height == 8'd0))
      else $error("negative height not clamped to zero");

   a_lattice_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (v5_ff[0][0] <= 25'sd8388608 && v5_ff[0][0] >= -25'sd8388608))
      else $error("lattice value out of range");

endmodule

>>> tb/fbm_value_noise_height_sampler_tb.sv
module fbm_value_noise_height_sampler_tb;

   typedef struct packed {
      logic signed [23:0] wx;
      logic signed [23:0] wz;
   } column_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [23:0] req_world_x;
   logic signed [23:0] req_world_z;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [7:0]         rsp_height;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_index;
   logic [31:0]        csr_data;

   // shadow copy of the configuration
   logic [31:0] cfg_seed;
   logic [15:0] cfg_scale;
   logic [7:0]  cfg_base;
   logic [7:0]  cfg_amp;

   column_type  column_q[$];
   logic [7:0]  height_q[$];
   int          errors;
   int          idle_cycles;
   int          hold_off;
   bit          force_stall;
   bit          sender_enable;
   int          burst_left;
   int          gap_left;
   logic        req_ready_q;

   fbm_value_noise_height_sampler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_world_x(req_world_x), .req_world_z(req_world_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_height(rsp_height),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num * 2 + den) / (den * 2);
      return -((-num * 2 + den) / (den * 2));
   endfunction

   function automatic longint corner_level(logic [31:0] cx, logic [31:0] cz,
                                          logic [31:0] seed);
      logic [31:0] h;
      longint      m;
      h = seed ^ (cx * fbmvn_pkg::HASH_CX);
      h = {h[16:0], h[31:17]};
      h = h ^ (cz * fbmvn_pkg::HASH_CZ);
      h = h ^ (h >> 16);
      h = h * fbmvn_pkg::HASH_M1;
      h = h ^ (h >> 15);
      h = h * fbmvn_pkg::HASH_M2;
      h = h ^ (h >> 16);
      m = longint'(h & fbmvn_pkg::LAT_MASK);
      return round_div((2 * m - longint'(fbmvn_pkg::LAT_MASK)) * fbmvn_pkg::Q23_ONE,
                       longint'(fbmvn_pkg::LAT_MASK));
   endfunction

   function automatic longint fade(logic [15:0] t);
      logic [63:0] tt;
      logic [63:0] prod;
      tt = {48'd0, t};
      prod = tt * tt * (64'd196608 - 64'd2 * tt);
      return longint'((prod + 64'h80000000) >> 32);
   endfunction

   function automatic longint mix(longint a, longint b, longint s);
      return a + round_div((b - a) * s, 65536);
   endfunction

   function automatic longint octave_level(longint px, longint pz, logic [31:0] seed);
      logic [63:0] ux;
      logic [63:0] uz;
      logic [31:0] cx;
      logic [31:0] cz;
      longint      sx;
      longint      sz;
      ux = px;
      uz = pz;
      cx = ux[47:16];
      cz = uz[47:16];
      sx = fade(ux[15:0]);
      sz = fade(uz[15:0]);
      return mix(mix(corner_level(cx, cz, seed), corner_level(cx + 1, cz, seed), sx),
                 mix(corner_level(cx, cz + 1, seed), corner_level(cx + 1, cz + 1, seed),
                     sx), sz);
   endfunction

   function automatic logic [7:0] terrain_height(column_type c);
      longint sum;
      longint y;
      longint den;
      sum = 0;
      den = fbmvn_pkg::NORM_DEN;
      for (int i = 0; i < fbmvn_pkg::OCTAVES; i++) begin
         sum += octave_level(longint'(c.wx) * longint'(cfg_scale) * (64'sd1 <<< i),
                             longint'(c.wz) * longint'(cfg_scale) * (64'sd1 <<< i),
                             cfg_seed + 32'(fbmvn_pkg::SEED_STEP * i)) * (64'sd8 >>> i);
      end
      y = round_div(longint'(cfg_base) * den + longint'(cfg_amp) * sum, den);
      if (y < 0) y = 0;
      if (y > fbmvn_pkg::HEIGHT_LIMIT - 1) y = fbmvn_pkg::HEIGHT_LIMIT - 1;
      return y[7:0];
   endfunction

   task automatic write_reg(logic [7:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         fbmvn_pkg::REG_SEED:  cfg_seed  = value;
         fbmvn_pkg::REG_SCALE: cfg_scale = value[15:0];
         fbmvn_pkg::REG_BASE:  cfg_base  = value[7:0];
         fbmvn_pkg::REG_AMP:   cfg_amp   = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (column_q.size() != 0 || req_valid || height_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 24'sh7fffff - 24'($urandom_range(0, 3));
         1: return 24'sh800000 + 24'($urandom_range(0, 3));
         2: return 24'($urandom_range(0, 8)) - 24'sd4;
         3: return 24'($urandom_range(0, 4000)) - 24'sd2000;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic queue_random(int n);
      column_type c;
      for (int i = 0; i < n; i++) begin
         c.wx = rand_coord();
         c.wz = rand_coord();
         column_q.push_back(c);
      end
   endtask

   // driver: bursts with gaps, payload held until the transaction is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready_q)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (sender_enable && column_q.size() != 0) begin
            req_valid   <= 1'b1;
            req_world_x <= column_q[0].wx;
            req_world_z <= column_q[0].wz;
            void'(column_q.pop_front());
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ready as seen at the last rising edge, so the driver knows if it was taken
   always @(posedge clock) req_ready_q <= req_ready;

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (force_stall) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 9) < ($time / 40000 % 2 ? 10 : 6));
   end

   // monitor: prediction at acceptance, check at result, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            height_q.push_back(terrain_height('{wx: req_world_x, wz: req_world_z}));
         if (rsp_valid && rsp_ready) begin
            if (height_q.size() == 0) begin
               $display("%0t: unexpected height %0d", $time, rsp_height);
               errors++;
            end else begin
               if (rsp_height !== height_q[0]) begin
                  $display("%0t: height expected %0d actual %0d", $time, height_q[0],
                           rsp_height);
                  errors++;
               end
               void'(height_q.pop_front());
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("fbm_value_noise_height_sampler regression: fail");
            $finish;
         end
      end
   end

   initial begin
      column_type c;
      logic [31:0] seeds[4];
      logic [15:0] scales[4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_world_x = '0;
      req_world_z = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      errors = 0;
      idle_cycles = 0;
      force_stall = 1'b0;
      sender_enable = 1'b1;
      burst_left = 0;
      gap_left = 0;
      cfg_seed = 0;
      cfg_scale = 16'd1311;
      cfg_base = 8'd64;
      cfg_amp = 8'd32;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values, directed extremes
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            c.wx = (i == 0) ? 24'sh800000 : (i == 1) ? 24'sd0 : 24'sh7fffff;
            c.wz = (j == 0) ? 24'sh800000 : (j == 1) ? 24'sd0 : 24'sh7fffff;
            column_q.push_back(c);
         end
      end
      c.wx = 24'sd1; c.wz = -24'sd1; column_q.push_back(c);
      c.wx = 24'sh555555; c.wz = 24'shaaaaaa; column_q.push_back(c);
      drain();

      // extreme configuration: full scale and amplitude, wide value, bad index
      write_reg(fbmvn_pkg::REG_SCALE, 32'hffffffff);
      write_reg(fbmvn_pkg::REG_AMP, 32'h123456ff);
      write_reg(fbmvn_pkg::REG_BASE, 32'd128);
      write_reg(fbmvn_pkg::REG_SEED, 32'hffffffff);
      write_reg(8'd7, 32'd0);
      write_reg(8'hff, 32'hdeadbeef);
      // cell wrap: large scale at the top of the range
      c.wx = 24'sh7fffff; c.wz = 24'sh7fffff; column_q.push_back(c);
      c.wx = 24'sh800000; c.wz = 24'sh7fffff; column_q.push_back(c);
      c.wx = -24'sd1; c.wz = -24'sd1; column_q.push_back(c);
      queue_random(8);
      drain();

      // long receiver hold-off with the sender still offering
      force_stall = 1'b1;
      queue_random(60);
      hold_off = 0;
      while (hold_off < 200) begin
         @(posedge clock);
         hold_off++;
      end
      force_stall = 1'b0;
      drain();

      seeds  = '{32'd0, 32'hffffffff, 32'h9e3779b9, 32'd12345};
      scales = '{16'd0, 16'd1, 16'hffff, 16'd1311};
      for (int p = 0; p < 6; p++) begin
         write_reg(fbmvn_pkg::REG_SEED, (p < 4) ? seeds[p] : $urandom);
         write_reg(fbmvn_pkg::REG_SCALE, (p < 4) ? scales[p] : $urandom_range(0, 65535));
         write_reg(fbmvn_pkg::REG_BASE,
                   (p == 0) ? 0 : (p == 1) ? 255 : $urandom_range(0, 255));
         write_reg(fbmvn_pkg::REG_AMP,
                   (p == 2) ? 0 : (p == 3) ? 255 : $urandom_range(0, 255));
         queue_random(280);
         drain();
      end

      if (errors == 0)
         $display("fbm_value_noise_height_sampler regression: pass");
      else
         $display("fbm_value_noise_height_sampler regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/fbmvn_pkg.sv
rtl/fbm_value_noise_height_sampler.sv
tb/fbm_value_noise_height_sampler_tb.sv
